### design/mfap_pkg.sv
package mfap_pkg;

    localparam int unsigned MAX_VERTICES = 32;
    localparam int unsigned VW           = 5;
    localparam int unsigned CAP_BITS     = 16;
    localparam int unsigned RES_BITS     = 17;
    localparam int unsigned ADDR_W       = 2 * VW;
    localparam int unsigned MAT_DEPTH    = MAX_VERTICES * MAX_VERTICES;
    localparam int unsigned STACK_DEPTH  = 1024;
    localparam int unsigned SP_W         = 10;
    localparam int unsigned FLOW_W       = 21;
    localparam int unsigned PATH_W       = 16;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_RUN   = 2'd2;

    localparam logic [1:0] REG_VCOUNT = 2'd0;
    localparam logic [1:0] REG_SOURCE = 2'd1;
    localparam logic [1:0] REG_SINK   = 2'd2;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [VW-1:0]       from_vertex;
        logic [VW-1:0]       to_vertex;
        logic [CAP_BITS-1:0] capacity;
    } in_item_t;

    typedef struct packed {
        logic [FLOW_W-1:0] total_flow;
        logic [PATH_W-1:0] path_count;
        logic              status;
    } out_item_t;

endpackage

### design/mfap_ram.sv
module mfap_ram #(
    parameter int unsigned DEPTH = 1024,
    parameter int unsigned WIDTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write one entry and read one entry; the read data is registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/max_flow_augmenting_paths_core.sv
// channel | direction | handshake             | payload
// cfg     | in        | cfg_we                | cfg_index, cfg_data
// in      | in        | in_valid & in_ready   | in_item (cmd, vertices, capacity)
// out     | out       | out_valid & out_ready | out_item (flow, paths, status)
// A clear sweeps 1024 capacity entries, one a cycle. A run copies 1024 entries into
// the residual memory; each pop then reads the stack top, and a newly visited vertex
// adds a scan of its row. A path is walked edge by edge for its bottleneck
// (S_NECKW, S_NECK) and then edge by edge again to update it (S_UPR, S_UPF, S_UPB).
// After reset a pass clears all 1024 capacity entries; no item is taken.
// The result register holds until taken; the next item waits for it.
module max_flow_augmenting_paths_core
    import mfap_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_item
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_COPY  = 4'd2;
    localparam logic [3:0] S_SINIT = 4'd3;
    localparam logic [3:0] S_POP   = 4'd4;
    localparam logic [3:0] S_SCAN  = 4'd5;
    localparam logic [3:0] S_NECK  = 4'd6;
    localparam logic [3:0] S_UPF   = 4'd7;
    localparam logic [3:0] S_UPB   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;
    localparam logic [3:0] S_SCANW = 4'd10;
    localparam logic [3:0] S_NECKW = 4'd11;
    localparam logic [3:0] S_UPR   = 4'd12;

    logic [3:0]          state_reg;
    logic [ADDR_W:0]     cnt_reg;
    logic [5:0]          vcount_reg;
    logic [VW-1:0]       src_reg, dst_reg;
    logic [5:0]          nv;
    logic [MAX_VERTICES-1:0] visited_reg;
    logic [VW-1:0]       parent_reg [MAX_VERTICES];
    logic [SP_W:0]       sp_reg;
    logic [VW-1:0]       u_reg, v_reg, w_reg;
    logic [5:0]          steps_reg;
    logic [RES_BITS-1:0] neck_reg;
    logic [FLOW_W+1:0]   flow_reg;
    logic [PATH_W-1:0]   paths_reg;
    logic                out_valid_reg;
    out_item_t           out_reg;
    logic                scan_first_reg;

    // capacity memory
    logic                cap_we;
    logic [ADDR_W-1:0]   cap_waddr, cap_raddr;
    logic [CAP_BITS-1:0] cap_wdata, cap_rdata;
    // residual memory
    logic                res_we;
    logic [ADDR_W-1:0]   res_waddr, res_raddr;
    logic [RES_BITS-1:0] res_wdata, res_rdata;
    // stack memory
    logic                stk_we;
    logic [SP_W-1:0]     stk_waddr, stk_raddr;
    logic [VW-1:0]       stk_wdata, stk_rdata;

    mfap_ram #(.DEPTH(MAT_DEPTH), .WIDTH(CAP_BITS)) u_cap (
        .clk(clk), .we(cap_we), .waddr(cap_waddr), .wdata(cap_wdata),
        .raddr(cap_raddr), .rdata(cap_rdata));
    mfap_ram #(.DEPTH(MAT_DEPTH), .WIDTH(RES_BITS)) u_res (
        .clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
        .raddr(res_raddr), .rdata(res_rdata));
    mfap_ram #(.DEPTH(STACK_DEPTH), .WIDTH(VW)) u_stk (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata));

    assign nv        = (vcount_reg > 6'(MAX_VERTICES)) ? 6'(MAX_VERTICES) : vcount_reg;
    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // scan index w and parent of current path vertex
    logic [VW-1:0] scan_v;
    logic [VW-1:0] par_v;
    logic          in_acc;
    assign scan_v = w_reg;
    assign par_v  = parent_reg[v_reg];
    assign in_acc = in_valid && in_ready;

    // memory port control
    always_comb
    begin
        cap_we    = 1'b0;
        cap_waddr = cnt_reg[ADDR_W-1:0];
        cap_wdata = '0;
        cap_raddr = cnt_reg[ADDR_W-1:0];
        res_we    = 1'b0;
        res_waddr = cnt_reg[ADDR_W-1:0] - 1'b1;
        res_wdata = {1'b0, cap_rdata};
        res_raddr = {u_reg, scan_v};
        stk_we    = 1'b0;
        stk_waddr = sp_reg[SP_W-1:0];
        stk_wdata = scan_v;
        stk_raddr = sp_reg[SP_W-1:0] - 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                cap_we = 1'b1;
            end
            S_IDLE:
            begin
                if (in_acc && in_item.cmd == CMD_WRITE)
                begin
                    cap_we    = 1'b1;
                    cap_waddr = {in_item.from_vertex, in_item.to_vertex};
                    cap_wdata = in_item.capacity;
                end
                cap_raddr = '0;
            end
            S_COPY:
            begin
                res_we = (cnt_reg != '0);
            end
            S_SINIT:
            begin
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = src_reg;
            end
            S_SCAN:
            begin
                res_raddr = {u_reg, scan_v - 1'b1};
                stk_we = !scan_first_reg && res_rdata != '0 && !visited_reg[scan_v]
                    && !sp_reg[SP_W];
            end
            S_NECK, S_NECKW, S_UPR:
            begin
                res_raddr = {par_v, v_reg};
            end
            S_UPF:
            begin
                res_raddr = {v_reg, par_v};
                res_we    = 1'b1;
                res_waddr = {par_v, v_reg};
                res_wdata = res_rdata - neck_reg;
            end
            S_UPB:
            begin
                res_raddr = {v_reg, par_v};
                res_we    = 1'b1;
                res_waddr = {v_reg, par_v};
                res_wdata = res_rdata + neck_reg;
            end
            default:
            begin
            end
        endcase
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= 6'd32;
            src_reg    <= '0;
            dst_reg    <= 5'd31;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_VCOUNT) vcount_reg <= cfg_data;
            if (cfg_index == REG_SOURCE) src_reg    <= cfg_data[VW-1:0];
            if (cfg_index == REG_SINK)   dst_reg    <= cfg_data[VW-1:0];
        end
    end

    // parent links: record the pushing vertex
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SCAN && !scan_first_reg && res_rdata != '0
            && !visited_reg[scan_v])
        begin
            parent_reg[scan_v] <= u_reg;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cnt_reg        <= '0;
            visited_reg    <= '0;
            sp_reg         <= '0;
            u_reg          <= '0;
            v_reg          <= '0;
            w_reg          <= '0;
            steps_reg      <= '0;
            neck_reg       <= '0;
            flow_reg       <= '0;
            paths_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
            scan_first_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg[ADDR_W-1:0] == '1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (in_acc)
                    begin
                        if (in_item.cmd == CMD_CLEAR)
                        begin
                            state_reg <= S_CLEAR;
                        end
                        else if (in_item.cmd == CMD_RUN)
                        begin
                            if (src_reg == dst_reg)
                            begin
                                out_reg       <= '{total_flow: '0, path_count: '0, status: 1'b1};
                                out_valid_reg <= 1'b1;
                            end
                            else if ({1'b0, src_reg} >= nv || {1'b0, dst_reg} >= nv)
                            begin
                                out_reg       <= '0;
                                out_valid_reg <= 1'b1;
                            end
                            else
                            begin
                                flow_reg  <= '0;
                                paths_reg <= '0;
                                cnt_reg   <= 11'd1;
                                state_reg <= S_COPY;
                            end
                        end
                    end
                end
                S_COPY:
                begin
                    // read of entry cnt is issued at cnt; the write at cnt stores entry cnt-1
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 11'd1024)
                    begin
                        state_reg <= S_SINIT;
                    end
                end
                S_SINIT:
                begin
                    visited_reg <= '0;
                    sp_reg      <= 11'd1;
                    state_reg   <= S_POP;
                end
                S_POP:
                begin
                    // issue the read of the top entry; data arrives in S_SCANW
                    if (sp_reg == '0)
                    begin
                        out_reg.total_flow <= (flow_reg > (FLOW_W+2)'(2097151))
                            ? FLOW_W'(2097151) : flow_reg[FLOW_W-1:0];
                        out_reg.path_count <= paths_reg;
                        out_reg.status     <= 1'b0;
                        state_reg          <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_SCANW;
                        sp_reg    <= sp_reg - 1'b1;
                    end
                end
                S_SCANW:
                begin
                    u_reg <= stk_rdata;
                    if ({1'b0, stk_rdata} >= nv)
                    begin
                        state_reg <= S_POP;
                    end
                    else if (stk_rdata == dst_reg)
                    begin
                        v_reg     <= dst_reg;
                        steps_reg <= '0;
                        neck_reg  <= '1;
                        state_reg <= S_NECKW;
                    end
                    else if (visited_reg[stk_rdata])
                    begin
                        state_reg <= S_POP;
                    end
                    else
                    begin
                        visited_reg[stk_rdata] <= 1'b1;
                        w_reg          <= nv[VW-1:0];
                        scan_first_reg <= 1'b1;
                        state_reg      <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // res_rdata holds row u, column w (not yet valid while scan_first_reg is set)
                    scan_first_reg <= 1'b0;
                    if (!scan_first_reg)
                    begin
                        if (res_rdata != '0 && !visited_reg[scan_v] && !sp_reg[SP_W])
                        begin
                            sp_reg <= sp_reg + 1'b1;
                        end
                    end
                    w_reg <= w_reg - 1'b1;
                    if (!scan_first_reg && scan_v == '0)
                    begin
                        state_reg <= S_POP;
                    end
                end
                S_NECKW:
                begin
                    if (v_reg == src_reg || steps_reg >= nv)
                    begin
                        v_reg     <= dst_reg;
                        steps_reg <= '0;
                        state_reg <= S_UPR;
                    end
                    else
                    begin
                        state_reg <= S_NECK;
                    end
                end
                S_NECK:
                begin
                    if (res_rdata < neck_reg)
                    begin
                        neck_reg <= res_rdata;
                    end
                    v_reg     <= par_v;
                    steps_reg <= steps_reg + 1'b1;
                    state_reg <= S_NECKW;
                end
                S_UPR:
                begin
                    // issue the forward read, or close the path
                    if (v_reg == src_reg || steps_reg >= nv)
                    begin
                        flow_reg  <= flow_reg + (FLOW_W+2)'(neck_reg);
                        if (paths_reg != '1)
                        begin
                            paths_reg <= paths_reg + 1'b1;
                        end
                        state_reg <= S_SINIT;
                    end
                    else
                    begin
                        state_reg <= S_UPF;
                    end
                end
                S_UPF:
                begin
                    state_reg <= S_UPB;
                end
                S_UPB:
                begin
                    v_reg     <= par_v;
                    steps_reg <= steps_reg + 1'b1;
                    state_reg <= S_UPR;
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
